>>> rtl/skvt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sorted key-value table.
package skvt_pkg;

   // Default sizing
   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_WIDTH_DEF = 31;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int VAL_W    = 31;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 1;

   // Opcodes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
   localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_VALUE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_VALID = 1'd1;

   // Memory read address selection
   localparam logic [1:0] RD_NONE  = 2'd0;
   localparam logic [1:0] RD_MID   = 2'd1;
   localparam logic [1:0] RD_LO    = 2'd2;
   localparam logic [1:0] RD_PREV  = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;        // capture the accepted request
      logic       clear;       // empty the table
      logic       srch_init;   // lo = 0, hi = fill count
      logic       step;        // narrow the search window
      logic       final_chk;   // capture hit flag and value
      logic       shift_init;  // shift index = fill count
      logic       shift_step;  // move read entry up one place
      logic       shift_far;   // read two below shift index
      logic       ins_write;   // write the new pair, bump fill count
      logic       set_dup;
      logic       set_full;
      logic       rsp_load;    // load the output register
      logic [1:0] rd_sel;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            search_more;
      logic            empty;
      logic            full;
      logic            key_greater;
      logic            key_equal;
      logic            idx_zero;
      logic            idx_one;
      logic            rsp_free;
   } sts_type;

endpackage

>>> rtl/skvt_datapath.sv
// Datapath: pair memory, search and shift counters, config registers and output register.
module skvt_datapath #(
   parameter int CAPACITY  = skvt_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  skvt_pkg::cmd_type               cmd,
   output skvt_pkg::sts_type               sts,
   input  logic [skvt_pkg::OP_W-1:0]       req_opcode,
   input  logic [KEY_WIDTH-1:0]            req_key,
   input  logic [skvt_pkg::VAL_W-1:0]      req_value,
   input  logic                            csr_we,
   input  logic [skvt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [skvt_pkg::VAL_W-1:0]      csr_wdata,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [skvt_pkg::STAT_W-1:0]     rsp_status,
   output logic                            rsp_found,
   output logic                            rsp_value_valid,
   output logic [skvt_pkg::VAL_W-1:0]      rsp_result_value,
   output logic [$clog2(CAPACITY+1)-1:0]   rsp_entry_count
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int VAL_W   = skvt_pkg::VAL_W;
   localparam int ENTRY_W = KEY_WIDTH + VAL_W;

   // Request operands
   logic [skvt_pkg::OP_W-1:0] op_ff;
   logic [KEY_WIDTH-1:0]      key_ff;
   logic [VAL_W-1:0]          val_ff;

   // Counters
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] idx_m1;
   logic [CNT_W-1:0] idx_m2;

   // Memory
   logic [ENTRY_W-1:0] mem [CAPACITY];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [VAL_W-1:0]     rd_val;

   // Search result and status
   logic                        hit_ff;
   logic [VAL_W-1:0]            hit_val_ff;
   logic [skvt_pkg::STAT_W-1:0] stat_ff;

   // Configuration
   logic [VAL_W-1:0] def_value_ff;
   logic             def_valid_ff;

   // Output register
   logic                        rsp_valid_ff;
   logic [skvt_pkg::STAT_W-1:0] rsp_status_ff;
   logic                        rsp_found_ff;
   logic                        rsp_vvalid_ff;
   logic [VAL_W-1:0]            rsp_value_ff;
   logic [CNT_W-1:0]            rsp_count_ff;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_m1 = idx_ff - CNT_W'(1);
   assign idx_m2 = idx_ff - CNT_W'(2);
   assign rd_key = rd_data_ff[KEY_WIDTH-1:0];
   assign rd_val = rd_data_ff[KEY_WIDTH +: VAL_W];

   // Status toward the controller
   always_comb begin
      sts.opcode      = op_ff;
      sts.search_more = (hi_ff - lo_ff) > CNT_W'(1);
      sts.empty       = (fill_ff == '0);
      sts.full        = (fill_ff >= CNT_W'(CAPACITY));
      sts.key_greater = (rd_key > key_ff);
      sts.key_equal   = (rd_key == key_ff);
      sts.idx_zero    = (idx_ff == '0);
      sts.idx_one     = (idx_ff == CNT_W'(1));
      sts.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   // Select read address
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      unique case (cmd.rd_sel)
         skvt_pkg::RD_MID: rd_addr = mid[ADDR_W-1:0];
         skvt_pkg::RD_LO:  rd_addr = lo_ff[ADDR_W-1:0];
         skvt_pkg::RD_PREV: begin
            rd_addr = cmd.shift_far ? idx_m2[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];
         end
         default: rd_en = 1'b0;
      endcase
   end

   // Select write data: shifted entry or the new pair
   assign wr_en   = cmd.shift_step || cmd.ins_write;
   assign wr_data = cmd.ins_write ? {val_ff, key_ff} : rd_data_ff;

   // Pair memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff[ADDR_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next counter values
   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      idx_in  = idx_ff;
      fill_in = fill_ff;
      if (cmd.srch_init) begin
         lo_in = '0;
         hi_in = fill_ff;
      end
      if (cmd.step) begin
         if (rd_key > key_ff) begin
            hi_in = mid;
         end else begin
            lo_in = mid;
         end
      end
      if (cmd.shift_init) begin
         idx_in = fill_ff;
      end
      if (cmd.shift_step) begin
         idx_in = idx_m1;
      end
      if (cmd.ins_write) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      if (cmd.clear) begin
         fill_in = '0;
      end
   end

   // Counters and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      idx_ff <= idx_in;
   end

   // Capture request, search outcome and status code
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         key_ff  <= req_key;
         val_ff  <= req_value;
         stat_ff <= skvt_pkg::ST_OK;
      end else if (cmd.set_dup) begin
         stat_ff <= skvt_pkg::ST_DUP;
      end else if (cmd.set_full) begin
         stat_ff <= skvt_pkg::ST_FULL;
      end
      if (cmd.srch_init) begin
         hit_ff <= 1'b0;
      end else if (cmd.final_chk) begin
         hit_ff     <= (rd_key == key_ff);
         hit_val_ff <= rd_val;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         def_value_ff <= '0;
         def_valid_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            skvt_pkg::CSR_DEFAULT_VALUE: def_value_ff <= csr_wdata;
            skvt_pkg::CSR_DEFAULT_VALID: def_valid_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Output register: load on finish, drop after transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_count_ff  <= fill_ff;
         if (op_ff == skvt_pkg::OP_LOOKUP) begin
            rsp_found_ff  <= hit_ff;
            rsp_vvalid_ff <= hit_ff || def_valid_ff;
            rsp_value_ff  <= hit_ff ? hit_val_ff : (def_valid_ff ? def_value_ff : '0);
         end else begin
            rsp_found_ff  <= 1'b0;
            rsp_vvalid_ff <= 1'b0;
            rsp_value_ff  <= '0;
         end
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_value_valid  = rsp_vvalid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

>>> rtl/skvt_ctrl.sv
// Controller: sequences search, shift, insert and result load for one request at a time.
module skvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  skvt_pkg::sts_type sts,
   output skvt_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE        = 4'd0;
   localparam logic [3:0] S_DECODE      = 4'd1;
   localparam logic [3:0] S_SRCH_RD     = 4'd2;
   localparam logic [3:0] S_SRCH_CHK    = 4'd3;
   localparam logic [3:0] S_FINAL       = 4'd4;
   localparam logic [3:0] S_SHIFT_START = 4'd5;
   localparam logic [3:0] S_SHIFT_CHK   = 4'd6;
   localparam logic [3:0] S_INS_WR      = 4'd7;
   localparam logic [3:0] S_RESP        = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = skvt_pkg::RD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.opcode)
               skvt_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_RESP;
               end
               skvt_pkg::OP_INSERT, skvt_pkg::OP_LOOKUP: begin
                  cmd.srch_init = 1'b1;
                  if (!sts.empty) begin
                     state_in = S_SRCH_RD;
                  end else if (sts.opcode == skvt_pkg::OP_INSERT) begin
                     cmd.shift_init = 1'b1;
                     state_in       = S_SHIFT_START;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_SRCH_RD: begin
            if (sts.search_more) begin
               cmd.rd_sel = skvt_pkg::RD_MID;
               state_in   = S_SRCH_CHK;
            end else begin
               cmd.rd_sel = skvt_pkg::RD_LO;
               state_in   = S_FINAL;
            end
         end
         S_SRCH_CHK: begin
            cmd.step = 1'b1;
            state_in = S_SRCH_RD;
         end
         S_FINAL: begin
            cmd.final_chk = 1'b1;
            priority if (sts.opcode != skvt_pkg::OP_INSERT) begin
               state_in = S_RESP;
            end else if (sts.key_equal) begin
               cmd.set_dup = 1'b1;
               state_in    = S_RESP;
            end else if (sts.full) begin
               cmd.set_full = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT_START;
            end
         end
         S_SHIFT_START: begin
            if (sts.idx_zero) begin
               state_in = S_INS_WR;
            end else begin
               cmd.rd_sel = skvt_pkg::RD_PREV;
               state_in   = S_SHIFT_CHK;
            end
         end
         S_SHIFT_CHK: begin
            // move larger entry up and fetch the next one below
            if (sts.key_greater) begin
               cmd.shift_step = 1'b1;
               if (sts.idx_one) begin
                  state_in = S_INS_WR;
               end else begin
                  cmd.rd_sel    = skvt_pkg::RD_PREV;
                  cmd.shift_far = 1'b1;
               end
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.ins_write = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/sorted_key_value_table.sv
// Sorted key-value table: top level joining controller and datapath to the stream ports.
//
// Holds up to CAPACITY key/value pairs in increasing key order in one single-port-write,
// registered-read memory, and works on one request at a time. A clear empties the table.
// A lookup runs a binary search, each step costing a memory read and a compare, then reads
// and checks the last candidate; on an empty table it goes straight to the result. An
// insert runs the same search and, unless the key is present or the table is full, moves
// each larger entry up a place through the one memory port, then writes the new pair; an
// insert into an empty table skips the search. The result sits in an output register, so a
// new request is taken while the previous result waits for its transfer; that request
// then holds in its last cycle until the waiting result is taken. Configuration writes are
// taken at any time the block is idle.
module sorted_key_value_table #(
   parameter int CAPACITY  = skvt_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // opcode, key, entry_value (lowest first), zero padded
   input  logic [((skvt_pkg::OP_W + KEY_WIDTH + skvt_pkg::VAL_W + 7) / 8) * 8 - 1:0]
                                                        req_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // status, found, value_valid, result_value, entry_count (lowest first), zero padded
   output logic [((skvt_pkg::STAT_W + 2 + skvt_pkg::VAL_W + $clog2(CAPACITY + 1) + 7) / 8)
                 * 8 - 1:0]                              rsp_tdata,
   input  logic                                         csr_we,
   input  logic [skvt_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [skvt_pkg::VAL_W-1:0]                   csr_wdata
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int OP_W    = skvt_pkg::OP_W;
   localparam int VAL_W   = skvt_pkg::VAL_W;
   localparam int STAT_W  = skvt_pkg::STAT_W;
   localparam int RSP_USED = STAT_W + 2 + VAL_W + CNT_W;
   localparam int RSP_W   = ((RSP_USED + 7) / 8) * 8;

   skvt_pkg::cmd_type cmd;
   skvt_pkg::sts_type sts;

   logic [STAT_W-1:0] rsp_status;
   logic              rsp_found;
   logic              rsp_value_valid;
   logic [VAL_W-1:0]  rsp_result_value;
   logic [CNT_W-1:0]  rsp_entry_count;

   skvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   skvt_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_tdata[OP_W-1:0]),
      .req_key          (req_tdata[OP_W +: KEY_WIDTH]),
      .req_value        (req_tdata[OP_W + KEY_WIDTH +: VAL_W]),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_value_valid  (rsp_value_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_entry_count  (rsp_entry_count)
   );

   // Pack the result fields, lowest first
   assign rsp_tdata = RSP_W'({rsp_entry_count, rsp_result_value, rsp_value_valid,
                              rsp_found, rsp_status});

endmodule

>>> rtl/skvt_checker.sv
// Port-level checker for the sorted key-value table, bound to the top level.
module skvt_checker #(
   parameter int CAPACITY  = skvt_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = skvt_pkg::KEY_WIDTH_DEF
) (
   input logic                                         clock,
   input logic                                         reset,
   input logic                                         rsp_tvalid,
   input logic                                         rsp_tready,
   input logic [((skvt_pkg::STAT_W + 2 + skvt_pkg::VAL_W + $clog2(CAPACITY + 1) + 7) / 8)
                * 8 - 1:0]                              rsp_tdata
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int STAT_W = skvt_pkg::STAT_W;
   localparam int CNT_LO = STAT_W + 2 + skvt_pkg::VAL_W;

   logic [STAT_W-1:0] status;
   logic              found;
   logic              value_valid;
   logic [CNT_W-1:0]  entry_count;

   assign status      = rsp_tdata[STAT_W-1:0];
   assign found       = rsp_tdata[STAT_W];
   assign value_valid = rsp_tdata[STAT_W + 1];
   assign entry_count = rsp_tdata[CNT_LO +: CNT_W];

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Entry count never exceeds capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> entry_count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // A hit carries a valid value and ok status
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && found |-> value_valid && status == skvt_pkg::ST_OK)
      else $error("hit without valid value or with error status");

   // Full and duplicate are insert errors: no lookup data alongside
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == skvt_pkg::ST_FULL || status == skvt_pkg::ST_DUP)
      |-> !found && !value_valid)
      else $error("error status with lookup data");

endmodule

bind sorted_key_value_table skvt_checker #(
   .CAPACITY  (CAPACITY),
   .KEY_WIDTH (KEY_WIDTH)
) u_skvt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
